// ===== rtl/dq_pkg.sv =====
// Package for the double-ended queue: command and status codes, cell control types.
// No dependencies; used by dq_cell and double_ended_queue_core.
package dq_pkg;

    localparam int DATA_W = 64;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SIZE       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ITERATE    = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_VALUE      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY_POP  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_SIZE       = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY_ITER = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL       = 3'd4;

    // Operation broadcast to every cell of the chain
    typedef enum logic [4:0] {
        CELL_HOLD       = 5'b00001,
        CELL_PUSH_FRONT = 5'b00010,
        CELL_PUSH_BACK  = 5'b00100,
        CELL_POP_FRONT  = 5'b01000,
        CELL_ROTATE     = 5'b10000
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic [DATA_W-1:0]       push_value;  // value entering at either end
        logic [DATA_W-1:0]       head_data;   // cell 0 contents, wraps to the back on rotate
    } t_cell_ctrl;

endpackage

// ===== rtl/dq_cell.sv =====
// One storage cell of the deque chain: an element register and its occupied flag.
// Depends on dq_pkg for the cell control struct.
module dq_cell import dq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_left_data,   // neighbor nearer the front
    input  logic              i_left_valid,
    input  logic [DATA_W-1:0] i_right_data,  // neighbor nearer the back
    input  logic              i_right_valid,
    output logic [DATA_W-1:0] o_data,
    output logic              o_valid
);

    logic [DATA_W-1:0] r_data, n_data;
    logic              r_valid, n_valid;

    // Next contents from the broadcast operation and the two neighbors
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        case (i_ctrl.op)
            CELL_PUSH_FRONT: begin
                n_data  = i_left_data;
                n_valid = i_left_valid;
            end
            CELL_PUSH_BACK: begin
                // first free cell takes the value
                if (!r_valid && i_left_valid) begin
                    n_data  = i_ctrl.push_value;
                    n_valid = 1'b1;
                end
            end
            CELL_POP_FRONT: begin
                n_data  = i_right_data;
                n_valid = i_right_valid;
            end
            CELL_ROTATE: begin
                // occupied cells move one toward the front, the head wraps to the back
                if (r_valid) begin
                    n_data = i_right_valid ? i_right_data : i_ctrl.head_data;
                end
            end
            default: begin
                n_data  = r_data;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// Double-ended queue of signed 64-bit values stored in a chain of CAPACITY cells.
// Push, pop front and size complete when accepted; a result sits in the output register.
// Pop back rotates the chain count-1 steps then pops the head.
// Iterate emits one element per cycle while the result output is free, by rotating the chain.
// Throughput: one transaction per cycle for push, pop front and size while the result output is free.
// Reset (synchronous, active low) empties the chain, count, FSM and output register.
module double_ended_queue_core import dq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [63:0] value
    input  logic [2:0]        s_tuser,   // [2:0] command
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // [63:0] data
    output logic [2:0]        m_tuser,   // [2:0] status
    output logic              m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ITER = 3'b010,
        ST_BACK = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_step, n_step;

    logic               r_m_valid, n_m_valid;
    logic [DATA_W-1:0]  r_m_data, n_m_data;
    logic [STAT_W-1:0]  r_m_status, n_m_status;
    logic               r_m_last, n_m_last;

    t_cell_ctrl         w_ctrl;
    t_cell_op           w_op;
    logic [DATA_W-1:0]  w_data  [CAPACITY];
    logic [CAPACITY-1:0] w_valid;

    logic               w_out_free;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_at_back;

    assign w_out_free = !r_m_valid || m_tready;
    assign s_tready   = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = s_tvalid && s_tready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_at_back  = (r_step == IDX_W'(r_count - CNT_W'(1)));

    // Command sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_step     = r_step;
        w_op       = CELL_HOLD;
        n_m_valid  = r_m_valid && !m_tready;
        n_m_data   = r_m_data;
        n_m_status = r_m_status;
        n_m_last   = r_m_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (s_tuser)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (w_full) begin
                                n_m_valid  = 1'b1;
                                n_m_status = STAT_FULL;
                                n_m_data   = '0;
                                n_m_last   = 1'b1;
                            end else begin
                                w_op    = (s_tuser == CMD_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                                      : CELL_PUSH_BACK;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            n_m_valid = 1'b1;
                            n_m_last  = 1'b1;
                            if (w_empty) begin
                                n_m_status = STAT_EMPTY_POP;
                                n_m_data   = '0;
                            end else begin
                                w_op       = CELL_POP_FRONT;
                                n_count    = r_count - CNT_W'(1);
                                n_m_status = STAT_VALUE;
                                n_m_data   = w_data[0];
                            end
                        end
                        CMD_POP_BACK: begin
                            if (w_empty) begin
                                n_m_valid  = 1'b1;
                                n_m_status = STAT_EMPTY_POP;
                                n_m_data   = '0;
                                n_m_last   = 1'b1;
                            end else begin
                                n_state = ST_BACK;
                                n_step  = '0;
                            end
                        end
                        CMD_SIZE: begin
                            n_m_valid  = 1'b1;
                            n_m_status = STAT_SIZE;
                            n_m_data   = DATA_W'(r_count);
                            n_m_last   = 1'b1;
                        end
                        CMD_ITERATE: begin
                            if (w_empty) begin
                                n_m_valid  = 1'b1;
                                n_m_status = STAT_EMPTY_ITER;
                                n_m_data   = '0;
                                n_m_last   = 1'b1;
                            end else begin
                                n_state = ST_ITER;
                                n_step  = '0;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ITER: begin
                // emit the head, then rotate it to the back; count rotations restore order
                if (w_out_free) begin
                    w_op       = CELL_ROTATE;
                    n_m_valid  = 1'b1;
                    n_m_status = STAT_VALUE;
                    n_m_data   = w_data[0];
                    n_m_last   = w_at_back;
                    if (w_at_back) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_step = r_step + IDX_W'(1);
                    end
                end
            end
            ST_BACK: begin
                // rotate until the back element reaches the head, then pop it
                if (w_at_back) begin
                    if (w_out_free) begin
                        w_op       = CELL_POP_FRONT;
                        n_count    = r_count - CNT_W'(1);
                        n_m_valid  = 1'b1;
                        n_m_status = STAT_VALUE;
                        n_m_data   = w_data[0];
                        n_m_last   = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    w_op   = CELL_ROTATE;
                    n_step = r_step + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_step    <= n_step;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data   <= n_m_data;
        r_m_status <= n_m_status;
        r_m_last   <= n_m_last;
    end

    assign w_ctrl.op         = w_op;
    assign w_ctrl.push_value = s_tdata;
    assign w_ctrl.head_data  = w_data[0];

    // Cell chain, cell 0 holds the front element
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_W-1:0] w_left_data, w_right_data;
            logic              w_left_valid, w_right_valid;
            if (g == 0) begin : g_first
                assign w_left_data  = s_tdata;
                assign w_left_valid = 1'b1;
            end else begin : g_mid_l
                assign w_left_data  = w_data[g-1];
                assign w_left_valid = w_valid[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right_data  = '0;
                assign w_right_valid = 1'b0;
            end else begin : g_mid_r
                assign w_right_data  = w_data[g+1];
                assign w_right_valid = w_valid[g+1];
            end
            dq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_left_data   (w_left_data),
                .i_left_valid  (w_left_valid),
                .i_right_data  (w_right_data),
                .i_right_valid (w_right_valid),
                .o_data        (w_data[g]),
                .o_valid       (w_valid[g])
            );
        end
    endgenerate

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_status;
    assign m_tlast  = r_m_last;

    // Occupied cells always match the element count
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_valid) == int'(r_count)))
        else $error("cell occupancy differs from count");

    // Occupied cells form a contiguous run from the front (one spare bit covers a full chain)
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones({1'b0, w_valid} + 1'b1) == 1))
        else $error("occupied cells not contiguous");

    // Iterate and pop back only run on a non-empty queue
    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_IDLE) |-> (r_count != '0)))
        else $error("iterate or pop back on empty queue");

    // The final iterate result returns the sequencer to idle
    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ITER) && w_out_free && w_at_back) |=> (r_state == ST_IDLE))
        else $error("iterate did not finish after last element");

endmodule

// ===== tb/double_ended_queue_checker.sv =====
// Result checker for double_ended_queue_core: keeps its own ring of elements, predicts the
// results of every input transaction and compares them with the result stream.
// Depends on dq_pkg for widths, command and status codes.
module double_ended_queue_checker import dq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [2:0]  s_tuser,   // [2:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [63:0] data
    input  logic [2:0]  m_tuser,   // [2:0] status
    input  logic        m_tlast,
    output int          o_err_count,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_deque_result;

    t_deque_result     awaited_results[$];
    logic [DATA_W-1:0] ring_slot [CAPACITY];
    int unsigned       front_pos;
    int unsigned       occupancy;
    int                mismatch_total;
    int                results_total;

    function automatic void await_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data,
                                         logic last);
        t_deque_result r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    // Apply one command to the shadow deque and queue the results it causes
    function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (occupancy >= CAPACITY) begin
                    await_result(STAT_FULL, '0, 1'b1);
                end else begin
                    front_pos = (front_pos + CAPACITY - 1) % CAPACITY;
                    ring_slot[front_pos] = value;
                    occupancy++;
                end
            end
            CMD_PUSH_BACK: begin
                if (occupancy >= CAPACITY) begin
                    await_result(STAT_FULL, '0, 1'b1);
                end else begin
                    ring_slot[(front_pos + occupancy) % CAPACITY] = value;
                    occupancy++;
                end
            end
            CMD_POP_FRONT: begin
                if (occupancy == 0) begin
                    await_result(STAT_EMPTY_POP, '0, 1'b1);
                end else begin
                    await_result(STAT_VALUE, ring_slot[front_pos], 1'b1);
                    front_pos = (front_pos + 1) % CAPACITY;
                    occupancy--;
                end
            end
            CMD_POP_BACK: begin
                if (occupancy == 0) begin
                    await_result(STAT_EMPTY_POP, '0, 1'b1);
                end else begin
                    await_result(STAT_VALUE, ring_slot[(front_pos + occupancy - 1) % CAPACITY],
                                 1'b1);
                    occupancy--;
                end
            end
            CMD_SIZE: begin
                await_result(STAT_SIZE, DATA_W'(occupancy), 1'b1);
            end
            CMD_ITERATE: begin
                if (occupancy == 0) begin
                    await_result(STAT_EMPTY_ITER, '0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < occupancy; i++) begin
                        await_result(STAT_VALUE, ring_slot[(front_pos + i) % CAPACITY],
                                     (i + 1 == occupancy));
                    end
                end
            end
            default: begin
                // the two spare command codes leave the deque untouched
            end
        endcase
    endfunction

    function automatic void log_failure(string what);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT) begin
            $display("[%0t] mismatch %0d: %s", $realtime, mismatch_total, what);
        end
    endfunction

    // Compare one result transaction with the oldest awaited result
    function automatic void compare_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data,
                                           logic last);
        t_deque_result want;
        results_total++;
        if (awaited_results.size() == 0) begin
            log_failure($sformatf("unexpected result status=%0d data=%h last=%b",
                                  status, data, last));
        end else begin
            want = awaited_results[0];
            awaited_results.delete(0);
            if (want.status !== status || want.data !== data || want.last !== last) begin
                log_failure($sformatf(
                    "want status=%0d data=%h last=%b, got status=%0d data=%h last=%b",
                    want.status, want.data, want.last, status, data, last));
            end
        end
    endfunction

    // Results first: a result can never stem from an input taken at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_results.delete();
            front_pos      = 0;
            occupancy      = 0;
            mismatch_total = 0;
            results_total  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                compare_result(m_tuser, m_tdata, m_tlast);
            end
            if (s_tvalid && s_tready) begin
                apply_command(s_tuser, s_tdata);
            end
        end
        o_err_count <= mismatch_total;
        o_pending   <= awaited_results.size();
        o_results   <= results_total;
    end

endmodule

// ===== tb/double_ended_queue_core_tb.sv =====
// Testbench top for double_ended_queue_core: drives command transactions with random gaps,
// a random-stall result sink and the final verdict. Depends on dq_pkg and
// double_ended_queue_checker, which predicts and compares the results.
module double_ended_queue_core_tb import dq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 64;
    localparam int HOLD_CYCLES = 500;

    // codes outside the command set, which the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] value
    logic [2:0]  s_tuser;   // [2:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] data
    logic [2:0]  m_tuser;   // [2:0] status
    logic        m_tlast;

    int err_count;
    int pending;
    int results_seen;
    int cycle_count = 0;
    int cmd_seen [8];
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;
    int stall_left = 0;

    double_ended_queue_core #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    double_ended_queue_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .o_err_count(err_count),
        .o_pending  (pending),
        .o_results  (results_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout with %0d results still awaited", pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result sink: long hold on request, otherwise short and occasional long stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle && $urandom_range(0, 99) < 25) begin
                    stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                            : $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '1;
            3:       return '0;
            4:       return DATA_W'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Pushes take push_pct percent, the rest is spread over the other commands
    function automatic logic [CMD_W-1:0] pick_command(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end
        r = $urandom_range(0, 99);
        if (r < 38) return CMD_POP_FRONT;
        if (r < 76) return CMD_POP_BACK;
        if (r < 86) return CMD_SIZE;
        if (r < 97) return CMD_ITERATE;
        return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    // Offer one command transaction and wait until the block takes it
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        int gap;
        int r;
        gap = 0;
        if (tx_idle) begin
            r = $urandom_range(0, 99);
            if (r >= 95)      gap = $urandom_range(8, 30);
            else if (r >= 65) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        cmd_seen[cmd]++;
    endtask

    // Stop offering until every awaited result is in, then let slow work settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2 * CAPACITY + 16) @(posedge i_clk);
    endtask

    initial begin
        int               counted;
        int               push_pct;
        logic [CMD_W-1:0] cmd;

        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_SIZE;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty cases, extremes, spare codes, both ends; ends empty
        send_item(CMD_POP_FRONT, pick_value());
        send_item(CMD_POP_BACK, pick_value());
        send_item(CMD_ITERATE, pick_value());
        send_item(CMD_SIZE, pick_value());
        send_item(CMD_PUSH_BACK, VAL_MAX);
        send_item(CMD_PUSH_FRONT, VAL_MIN);
        send_item(CMD_PUSH_BACK, '1);
        send_item(CMD_PUSH_FRONT, '0);
        send_item(CMD_SPARE_LO, pick_value());
        send_item(CMD_SPARE_HI, pick_value());
        send_item(CMD_SIZE, '0);
        send_item(CMD_ITERATE, '0);
        send_item(CMD_POP_BACK, '0);
        send_item(CMD_POP_FRONT, '0);
        send_item(CMD_POP_BACK, '0);
        send_item(CMD_POP_FRONT, '0);
        send_item(CMD_POP_BACK, '0);
        send_item(CMD_PUSH_FRONT, 64'h5555_5555_5555_5555);
        send_item(CMD_POP_BACK, '0);
        send_item(CMD_PUSH_BACK, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(CMD_ITERATE, '0);
        send_item(CMD_POP_FRONT, '0);
        send_item(CMD_SIZE, '0);
        drain_results();

        // Fill to capacity while the sink holds off, so results back up into the input
        tx_idle = 1'b0;
        rx_hold = HOLD_CYCLES;
        for (int k = 0; k < CAPACITY; k++) begin
            send_item(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
        end
        send_item(CMD_PUSH_FRONT, pick_value());
        send_item(CMD_PUSH_BACK, pick_value());
        repeat (8) send_item(CMD_SIZE, pick_value());
        send_item(CMD_ITERATE, pick_value());
        repeat (2) send_item(CMD_POP_BACK, pick_value());
        repeat (2) send_item(CMD_POP_FRONT, pick_value());
        drain_results();

        // Random phases sweeping the fill level up and down
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       push_pct = 80;
                1:       push_pct = 50;
                2:       push_pct = 30;
                3:       push_pct = 85;
                4:       push_pct = 55;
                default: push_pct = 20;
            endcase
            tx_idle = (p != 2);
            rx_idle = (p != 2 && p != 4);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                cmd = pick_command(push_pct);
                send_item(cmd, pick_value());
                if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) counted++;
            end
            if (p % 2 == 1) drain_results();
        end

        drain_results();
        $display("Sent %0d pushes, %0d pops, %0d size and %0d iterate commands, %0d spare codes",
                 cmd_seen[CMD_PUSH_FRONT] + cmd_seen[CMD_PUSH_BACK],
                 cmd_seen[CMD_POP_FRONT] + cmd_seen[CMD_POP_BACK],
                 cmd_seen[CMD_SIZE], cmd_seen[CMD_ITERATE],
                 cmd_seen[CMD_SPARE_LO] + cmd_seen[CMD_SPARE_HI]);
        $display("Checked %0d result transactions, %0d mismatches", results_seen, err_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
